### hdl/wlae_pkg.sv
// Shared types and constants of the wavelet LSB audio extractor.
package wlae_pkg;

    localparam int SMP_FIELD_W = 24;
    localparam int N_SMP       = 8;
    localparam int N_PAIR      = 4;
    localparam int N_COEF      = 6;
    localparam int FIELD_W     = 12;
    localparam int HDR_L1_W    = 6;
    localparam int HDR_L2_W    = 4;
    localparam int EXT_W       = 28;
    localparam int STREAM_W    = N_COEF * FIELD_W;
    localparam int NB_W        = 7;
    localparam int BYTE_W      = 8;
    localparam int BUF_W       = STREAM_W + BYTE_W;
    localparam int CNT_W       = 7;
    localparam int LEN_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int BITS_W      = 4;

    localparam logic [BITS_W-1:0] MAX_FIELD = 4'd12;

    localparam logic KIND_LENGTH = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_MESSAGE,
        PH_DONE
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEREO_MODE,
        REG_LEVEL1_BITS,
        REG_LEVEL2_BITS,
        REG_START_DEPTH
    } cfg_reg_t;

    typedef struct packed {
        logic              stereo;
        logic [BITS_W-1:0] l1_bits;
        logic [BITS_W-1:0] l2_bits;
        logic [BITS_W-1:0] depth;
    } cfg_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [NB_W-1:0]     nbits;
        logic [LEN_W-1:0]    length;
    } blk_t;

endpackage

### hdl/wlae_xform.sv
// Lifting transform pipeline and hidden-field extraction for one block.
module wlae_xform import wlae_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [N_SMP*SMP_FIELD_W-1:0] s_tdata,
    output logic                         blk_valid,
    input  logic                         blk_ready,
    output blk_t                         blk
);

    localparam int DW = SAMPLE_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] smp_reg [N_SMP];
    logic signed [DW-1:0]          pa [N_PAIR];
    logic signed [DW-1:0]          pb [N_PAIR];
    logic signed [DW-1:0]          d1_next [N_PAIR];
    logic signed [DW-1:0]          avg1_next [N_PAIR];
    logic signed [DW-1:0]          rnd [N_PAIR];
    logic signed [DW-1:0]          d1_reg [N_PAIR];
    logic signed [DW-1:0]          avg1_reg [N_PAIR];
    logic signed [DW-1:0]          d2 [2];
    logic signed [DW-1:0]          coef [N_COEF];
    logic                          is_l2 [N_COEF];
    logic signed [EXT_W-1:0]       sh [N_COEF];
    logic [FIELD_W-1:0]            fld [N_COEF];
    logic [FIELD_W-1:0]            f_al [N_COEF];
    logic [BITS_W-1:0]             wid [N_COEF];
    logic [NB_W-1:0]               off [N_COEF];
    logic [BITS_W-1:0]             n1;
    logic [BITS_W-1:0]             n2;
    logic [LEN_W-1:0]              hdr_word;
    blk_t                          blk_next;
    blk_t                          blk_reg;
    logic                          a_vld_reg, b_vld_reg, c_vld_reg;
    logic                          a_ready, b_ready, c_ready;

    assign c_ready   = !c_vld_reg || blk_ready;
    assign b_ready   = !b_vld_reg || c_ready;
    assign a_ready   = !a_vld_reg || b_ready;
    assign s_tready  = a_ready;
    assign blk_valid = c_vld_reg;
    assign blk       = blk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_vld_reg <= s_tvalid;
            end
            if (b_ready) begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_ready) begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_tvalid) begin
            for (int i = 0; i < N_SMP; i++) begin
                smp_reg[i] <= s_tdata[i*SMP_FIELD_W +: SAMPLE_BITS];
            end
        end
        if (b_ready && a_vld_reg) begin
            d1_reg   <= d1_next;
            avg1_reg <= avg1_next;
        end
        if (c_ready && b_vld_reg) begin
            blk_reg <= blk_next;
        end
    end

    // first level: stereo pairs per channel, mono pairs per half
    always_comb begin
        for (int p = 0; p < N_PAIR; p++) begin
            if (cfg.stereo) begin
                pa[p] = DW'(smp_reg[(p % 2) * 4 + p / 2]);
                pb[p] = DW'(smp_reg[(p % 2) * 4 + p / 2 + 2]);
            end else begin
                pa[p] = DW'(smp_reg[2 * p]);
                pb[p] = DW'(smp_reg[2 * p + 1]);
            end
            d1_next[p]   = pb[p] - pa[p];
            rnd[p]       = d1_next[p] + $signed({{(DW-1){1'b0}}, d1_next[p][DW-1]});
            avg1_next[p] = pa[p] + (rnd[p] >>> 1);
        end
    end

    // second level details, field extraction and bit packing
    always_comb begin
        d2[0] = avg1_reg[1] - avg1_reg[0];
        d2[1] = avg1_reg[3] - avg1_reg[2];
        if (cfg.stereo) begin
            coef[0] = d1_reg[0]; is_l2[0] = 1'b0;
            coef[1] = d1_reg[2]; is_l2[1] = 1'b0;
            coef[2] = d2[0];     is_l2[2] = 1'b1;
            coef[3] = d2[1];     is_l2[3] = 1'b1;
            coef[4] = d1_reg[1]; is_l2[4] = 1'b0;
            coef[5] = d1_reg[3]; is_l2[5] = 1'b0;
        end else begin
            coef[0] = d1_reg[0]; is_l2[0] = 1'b0;
            coef[1] = d2[0];     is_l2[1] = 1'b1;
            coef[2] = d1_reg[1]; is_l2[2] = 1'b0;
            coef[3] = d1_reg[2]; is_l2[3] = 1'b0;
            coef[4] = d2[1];     is_l2[4] = 1'b1;
            coef[5] = d1_reg[3]; is_l2[5] = 1'b0;
        end
        n1 = (cfg.l1_bits > MAX_FIELD) ? MAX_FIELD : cfg.l1_bits;
        n2 = (cfg.l2_bits > MAX_FIELD) ? MAX_FIELD : cfg.l2_bits;
        blk_next.stream = '0;
        for (int i = 0; i < N_COEF; i++) begin
            sh[i]   = EXT_W'(coef[i]) >>> cfg.depth;
            fld[i]  = sh[i][FIELD_W-1:0];
            wid[i]  = is_l2[i] ? n2 : n1;
            f_al[i] = FIELD_W'(fld[i] << (BITS_W'(FIELD_W) - wid[i]));
            if (i == 0) begin
                off[i] = '0;
            end else begin
                off[i] = off[i-1] + NB_W'(wid[i-1]);
            end
            blk_next.stream = blk_next.stream |
                ({f_al[i], {(STREAM_W-FIELD_W){1'b0}}} >> off[i]);
        end
        blk_next.nbits = off[N_COEF-1] + NB_W'(wid[N_COEF-1]);
        if (cfg.stereo) begin
            hdr_word = {fld[0][HDR_L1_W-1:0], fld[1][HDR_L1_W-1:0],
                        fld[2][HDR_L2_W-1:0], fld[3][HDR_L2_W-1:0],
                        fld[4][HDR_L1_W-1:0], fld[5][HDR_L1_W-1:0]};
        end else begin
            hdr_word = {fld[0][HDR_L1_W-1:0], fld[1][HDR_L2_W-1:0],
                        fld[2][HDR_L1_W-1:0], fld[3][HDR_L1_W-1:0],
                        fld[4][HDR_L2_W-1:0], fld[5][HDR_L1_W-1:0]};
        end
        blk_next.length = {hdr_word[7:0], hdr_word[15:8],
                           hdr_word[23:16], hdr_word[31:24]};
    end

endmodule

### hdl/wlae_drain.sv
// Bit buffer, message state and a result register that sends one byte per cycle while results are taken.
module wlae_drain import wlae_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              blk_valid,
    output logic              blk_ready,
    input  blk_t              blk,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [LEN_W-1:0]  m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);

    phase_t            phase_reg, phase_next, phase_e;
    logic [BUF_W-1:0]  buf_reg, buf_next, base_buf;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_e, base_cnt;
    logic [LEN_W-1:0]  rem_reg, rem_next, rem_e;
    logic              m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]  m_data_reg, m_data_next;
    logic              m_kind_reg, m_kind_next;
    logic              m_last_reg, m_last_next;
    logic              m_fin_reg, m_fin_next;
    logic              out_free, busy, emit, fin_e, after_ok, take;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_fin_reg, m_kind_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg    <= buf_next;
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
        m_fin_reg  <= m_fin_next;
    end

    always_comb begin
        out_free = !m_valid_reg || m_tready;
        busy     = (phase_reg == PH_MESSAGE) && (cnt_reg >= CNT_W'(BYTE_W));
        emit     = busy && out_free;
        cnt_e    = cnt_reg - CNT_W'(BYTE_W);
        rem_e    = rem_reg - LEN_W'(1);
        fin_e    = (rem_e == '0);
        after_ok = !busy || (emit && ((cnt_e < CNT_W'(BYTE_W)) || fin_e));
        phase_e  = (emit && fin_e) ? PH_DONE : phase_reg;
        take     = blk_valid && after_ok && ((phase_e != PH_HEADER) || out_free);
        base_buf = emit ? (buf_reg << BYTE_W) : buf_reg;
        base_cnt = emit ? cnt_e : cnt_reg;

        phase_next   = phase_reg;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;
        m_fin_next   = m_fin_reg;

        // advance one byte
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = LEN_W'(buf_reg[BUF_W-1 -: BYTE_W]);
            m_kind_next  = KIND_BYTE;
            m_last_next  = (cnt_e < CNT_W'(BYTE_W)) || fin_e;
            m_fin_next   = fin_e;
            rem_next     = rem_e;
            if (fin_e) begin
                phase_next = PH_DONE;
                cnt_next   = '0;
                buf_next   = '0;
            end else begin
                buf_next = base_buf;
                cnt_next = cnt_e;
            end
        end

        if (take) begin
            case (phase_e)
                PH_HEADER: begin
                    m_valid_next = 1'b1;
                    m_data_next  = blk.length;
                    m_kind_next  = KIND_LENGTH;
                    m_last_next  = 1'b1;
                    m_fin_next   = (blk.length == '0);
                    rem_next     = blk.length;
                    phase_next   = (blk.length == '0) ? PH_DONE : PH_MESSAGE;
                    cnt_next     = '0;
                    buf_next     = '0;
                end
                PH_MESSAGE: begin
                    buf_next = base_buf |
                        ({blk.stream, {(BUF_W-STREAM_W){1'b0}}} >> base_cnt[2:0]);
                    cnt_next = base_cnt + CNT_W'(blk.nbits);
                end
                default: begin
                    // drop the item
                end
            endcase
        end
    end

    assign blk_ready = take;

`ifndef SYNTH
    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) |-> (cnt_reg == '0))
        else $error("bits left in buffer after completion");
    a_hdr_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (cnt_reg == '0) && (rem_reg == '0))
        else $error("buffer not empty before header");
    a_msg_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_MESSAGE) |-> (rem_reg != '0))
        else $error("message phase with no bytes outstanding");
    a_final_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && fin_e) |=> (phase_reg == PH_DONE) && m_valid_reg && m_fin_reg)
        else $error("final byte did not end the message");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_W'(BUF_W))
        else $error("bit count beyond buffer");
`endif

endmodule

### hdl/wavelet_lsb_audio_extractor.sv
// Top level of the wavelet LSB audio extractor.
// Takes one block of eight PCM samples per item, runs a two-level integer Haar
// lifting transform on it and recovers the hidden bits from six detail
// coefficients. The first block yields the 32-bit message length; later blocks
// yield message bytes until that many bytes have been given, after which items
// are taken and dropped. An item passes three pipeline registers (samples,
// first-level results, packed block) to the byte drain, whose result register
// takes the length word directly; a message block first enters the bit buffer.
// New blocks are taken while earlier ones are in flight as long as the drain
// takes them; a block yielding n bytes (n at most nine) holds the drain until
// they have left, as one result register sends one byte per cycle while
// results are taken. Configuration takes effect on the next block and is to be
// written while no item is in flight.
module wavelet_lsb_audio_extractor import wlae_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // sample_0 .. sample_7, 24 bits each
    input  logic [N_SMP*SMP_FIELD_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // value
    output logic [LEN_W-1:0]             m_tdata,
    output logic                         m_tlast,
    // kind, finished
    output logic [1:0]                   m_tuser
);

    cfg_t cfg_reg;
    logic blk_valid;
    logic blk_ready;
    blk_t blk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stereo  <= 1'b1;
            cfg_reg.l1_bits <= 4'd7;
            cfg_reg.l2_bits <= 4'd5;
            cfg_reg.depth   <= 4'd0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_STEREO_MODE: cfg_reg.stereo  <= cfg_wdata[0];
                REG_LEVEL1_BITS: cfg_reg.l1_bits <= cfg_wdata;
                REG_LEVEL2_BITS: cfg_reg.l2_bits <= cfg_wdata;
                REG_START_DEPTH: cfg_reg.depth   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    wlae_xform #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk)
    );

    wlae_drain u_drain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
